@@ hdl/greedy_box_suppression_macros.svh @@
// Assertion macros used by the checker of the box suppression block.
// Each macro samples on the rising edge of clk and is off while arst_n is low.
`ifndef GREEDY_BOX_SUPPRESSION_MACROS_SVH
`define GREEDY_BOX_SUPPRESSION_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GBS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle rule");

// Consequent must hold in the cycle after the antecedent.
`define GBS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle rule");

`endif

@@ hdl/gbs_pkg.sv @@
// ----------------------------------------------------------------------------
// gbs_pkg
// Types and sizes shared by the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbs_pkg;

	localparam int MAX_KEPT   = 64;
	localparam int COORD_BITS = 16;
	localparam int SIZE_BITS  = COORD_BITS - 1;
	localparam int AREA_BITS  = 2 * SIZE_BITS;
	localparam int UNI_BITS   = AREA_BITS + 1;
	localparam int THR_BITS   = 9;
	localparam int FRAC_SHIFT = 8;
	localparam int PROD_BITS  = UNI_BITS + THR_BITS;
	localparam int EDGE_BITS  = COORD_BITS + 2;
	localparam int CNT_BITS   = $clog2(MAX_KEPT + 1);
	localparam int SLOT_BITS  = 6;
	localparam int IOU_LAT    = 6;
	localparam int SCAN_BITS  = $clog2(MAX_KEPT + IOU_LAT);
	localparam int SUM_BITS   = SCAN_BITS + 1;
	localparam int THR_RESET  = 115;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] left;
		logic signed [COORD_BITS-1:0] top;
		logic        [SIZE_BITS-1:0]  width;
		logic        [SIZE_BITS-1:0]  height;
	} box_t;

	typedef struct packed {
		box_t                 box;
		logic [AREA_BITS-1:0] area;
	} entry_t;

	typedef struct packed {
		logic rot;
		logic app;
	} chain_ctl_t;

endpackage

@@ hdl/greedy_box_suppression.sv @@
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Greedy IoU suppression of a score-ordered box stream against a kept list.
// ----------------------------------------------------------------------------
// Boxes enter on the in_valid/in_ready channel, one request at a time; each
// gives one result on the out_valid/out_ready channel: keep, kept_slot and
// list_full. in_ready is high only while no box is being scanned.
// An accepted box is tested against every kept entry by rotating the
// MAX_KEPT-cell kept list past one shared overlap pipeline of IOU_LAT stages.
// The scan rotates the row once through the pipeline and then drains it; the
// result is loaded into the output register and the block returns to idle, so
// a new box is accepted only after the previous result has been loaded.
// A finished result waits in the output register; the next box is accepted
// and scanned meanwhile, and its result holds in the last step until the
// receiver takes the previous one.
// The overlap threshold is written over the APB port at address 0.
// Reset empties the kept list, restores the threshold to 115 and drops any
// pending result; the list cells themselves are not cleared.
// ----------------------------------------------------------------------------
module greedy_box_suppression import gbs_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] box_left,
	input  logic signed [COORD_BITS-1:0] box_top,
	input  logic [SIZE_BITS-1:0]         box_width,
	input  logic [SIZE_BITS-1:0]         box_height,
	input  logic                         first_of_set,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         keep,
	output logic [SLOT_BITS-1:0]         kept_slot,
	output logic                         list_full
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam logic [SCAN_BITS-1:0] SCAN_LAST = SCAN_BITS'(MAX_KEPT + IOU_LAT - 1);
	localparam logic [SCAN_BITS-1:0] ROT_LAST  = SCAN_BITS'(MAX_KEPT - 1);

	logic [1:0]           state_q;
	logic [SCAN_BITS-1:0] scan_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [THR_BITS-1:0]  thr_q;
	logic                 supp_q;
	entry_t               cand_q;
	logic                 out_valid_q, keep_q, full_q;
	logic [SLOT_BITS-1:0] slot_q;

	logic       in_acc, cfg_wr, rot, issue, hit, finish, store;
	chain_ctl_t ctl;
	entry_t     head;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & ~paddr[2];
	assign prdata = paddr[2] ? 32'd0 : 32'(thr_q);

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid & in_ready;
	assign rot      = (state_q == ST_SCAN) && (scan_q <= ROT_LAST);
	// valid entries occupy the last cnt_q cells of the row
	assign issue    = rot && ((SUM_BITS'(scan_q) + SUM_BITS'(cnt_q)) >= SUM_BITS'(MAX_KEPT));
	assign finish   = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign store    = finish && !supp_q && (cnt_q < CNT_BITS'(MAX_KEPT));

	assign ctl.rot = rot;
	assign ctl.app = store;

	gbs_chain u_chain (
		.clk       (clk),
		.ctl       (ctl),
		.new_entry (cand_q),
		.head      (head)
	);

	gbs_iou u_iou (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (issue),
		.cand   (cand_q),
		.kept   (head),
		.thr    (thr_q),
		.hit    (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_BITS'(THR_RESET);
		end else if (cfg_wr) begin
			thr_q <= pwdata[THR_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_q      <= '0;
			cnt_q       <= '0;
			supp_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// load a finished result, else drop the one just taken
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_SCAN;
						scan_q  <= '0;
						supp_q  <= 1'b0;
						if (first_of_set) begin
							cnt_q <= '0;
						end
					end
				end
				ST_SCAN: begin
					supp_q <= supp_q | hit;
					scan_q <= scan_q + SCAN_BITS'(1);
					if (scan_q == SCAN_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (finish) begin
						state_q <= ST_IDLE;
						if (store) begin
							cnt_q <= cnt_q + CNT_BITS'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cand_q.box.left   <= box_left;
			cand_q.box.top    <= box_top;
			cand_q.box.width  <= box_width;
			cand_q.box.height <= box_height;
			cand_q.area       <= AREA_BITS'(box_width) * AREA_BITS'(box_height);
		end
		if (finish) begin
			keep_q <= !supp_q;
			full_q <= !supp_q && !store;
			slot_q <= store ? SLOT_BITS'(cnt_q) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign keep      = keep_q;
	assign kept_slot = slot_q;
	assign list_full = full_q;

endmodule

@@ hdl/gbs_cell.sv @@
// ----------------------------------------------------------------------------
// gbs_cell
// One slot of the kept list: holds a box and its area, loads from its neighbor.
// ----------------------------------------------------------------------------
module gbs_cell import gbs_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  entry_t d,
	output entry_t q
);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (en) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

@@ hdl/gbs_chain.sv @@
// ----------------------------------------------------------------------------
// gbs_chain
// Row of kept-list cells. Rotates toward the head during a scan and shifts a
// new entry in at the tail on append; valid entries sit at the tail end.
// ----------------------------------------------------------------------------
module gbs_chain import gbs_pkg::*; (
	input  logic       clk,
	input  chain_ctl_t ctl,
	input  entry_t     new_entry,
	output entry_t     head
);

	entry_t cell_q [MAX_KEPT];
	entry_t cell_d [MAX_KEPT];
	logic   shift_en;

	assign shift_en = ctl.rot | ctl.app;

	genvar i;
	generate
		for (i = 0; i < MAX_KEPT; i++) begin : g_cell
			if (i == MAX_KEPT - 1) begin : g_tail
				// wrap the head around on rotate, take the new box on append
				assign cell_d[i] = ctl.rot ? cell_q[0] : new_entry;
			end else begin : g_body
				assign cell_d[i] = cell_q[i+1];
			end
			gbs_cell u_cell (
				.clk (clk),
				.en  (shift_en),
				.d   (cell_d[i]),
				.q   (cell_q[i])
			);
		end
	endgenerate

	assign head = cell_q[0];

endmodule

@@ hdl/gbs_iou.sv @@
// ----------------------------------------------------------------------------
// gbs_iou
// Pipelined overlap test: flags inter*256 > threshold*union, union nonzero.
// ----------------------------------------------------------------------------
module gbs_iou import gbs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	input  entry_t              cand,
	input  entry_t              kept,
	input  logic [THR_BITS-1:0] thr,
	output logic                hit
);

	logic signed [EDGE_BITS-1:0] nl, nt, nr, nb, kl, kt, kr, kb;
	logic signed [EDGE_BITS-1:0] x0_c, y0_c, x1_c, y1_c;
	logic signed [EDGE_BITS-1:0] x0_s1, y0_s1, x1_s1, y1_s1;
	logic signed [EDGE_BITS-1:0] dx_c, dy_c;
	logic [AREA_BITS-1:0]        an_s1, ak_s1, an_s2, ak_s2, an_s3, ak_s3;
	logic [SIZE_BITS-1:0]        iw_s2, ih_s2;
	logic [AREA_BITS-1:0]        inter_s3, inter_s4;
	logic [UNI_BITS-1:0]         uni_s4;
	logic [PROD_BITS-1:0]        lhs_s5, rhs_s5;
	logic                        upos_s5;
	logic                        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                        hit_s6;

	assign nl = EDGE_BITS'(cand.box.left);
	assign nt = EDGE_BITS'(cand.box.top);
	assign kl = EDGE_BITS'(kept.box.left);
	assign kt = EDGE_BITS'(kept.box.top);
	assign nr = nl + $signed(EDGE_BITS'(cand.box.width));
	assign nb = nt + $signed(EDGE_BITS'(cand.box.height));
	assign kr = kl + $signed(EDGE_BITS'(kept.box.width));
	assign kb = kt + $signed(EDGE_BITS'(kept.box.height));

	assign x0_c = (nl > kl) ? nl : kl;
	assign y0_c = (nt > kt) ? nt : kt;
	assign x1_c = (nr < kr) ? nr : kr;
	assign y1_c = (nb < kb) ? nb : kb;

	assign dx_c = x1_s1 - x0_s1;
	assign dy_c = y1_s1 - y0_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			hit_s6 <= 1'b0;
		end else begin
			v_s1   <= valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			hit_s6 <= v_s5 & upos_s5 & (lhs_s5 > rhs_s5);
		end
	end

	always_ff @(posedge clk) begin
		x0_s1    <= x0_c;
		y0_s1    <= y0_c;
		x1_s1    <= x1_c;
		y1_s1    <= y1_c;
		an_s1    <= cand.area;
		ak_s1    <= kept.area;
		// overlap never exceeds the narrower side, so the low bits suffice
		iw_s2    <= (dx_c > 0) ? dx_c[SIZE_BITS-1:0] : '0;
		ih_s2    <= (dy_c > 0) ? dy_c[SIZE_BITS-1:0] : '0;
		an_s2    <= an_s1;
		ak_s2    <= ak_s1;
		inter_s3 <= AREA_BITS'(iw_s2) * AREA_BITS'(ih_s2);
		an_s3    <= an_s2;
		ak_s3    <= ak_s2;
		uni_s4   <= UNI_BITS'(an_s3) + UNI_BITS'(ak_s3) - UNI_BITS'(inter_s3);
		inter_s4 <= inter_s3;
		lhs_s5   <= PROD_BITS'({inter_s4, FRAC_SHIFT'(0)});
		rhs_s5   <= PROD_BITS'(thr) * PROD_BITS'(uni_s4);
		upos_s5  <= (uni_s4 != '0);
	end

	assign hit = hit_s6;

endmodule

@@ hdl/gbs_checker.sv @@
// ----------------------------------------------------------------------------
// gbs_checker
// Port-level checks of the box suppression block, bound to the top level.
// ----------------------------------------------------------------------------
`include "greedy_box_suppression_macros.svh"

module gbs_checker import gbs_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 keep,
	input logic [SLOT_BITS-1:0] kept_slot,
	input logic                 list_full
);

	// a stalled result holds
	`GBS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(keep) && $stable(kept_slot) && $stable(list_full))

	// a dropped box carries no slot and no full flag
	`GBS_ASSERT_SAME(a_drop_clean, out_valid && !keep, kept_slot == '0 && !list_full)

	// only a surviving box can overflow the list
	`GBS_ASSERT_SAME(a_full_keeps, out_valid && list_full, keep && kept_slot == '0)

	// an accepted box occupies the scan, so no second request follows at once
	`GBS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (.*);

@@ dv/greedy_box_suppression_test.sv @@
// ----------------------------------------------------------------------------
// greedy_box_suppression_test
// Self-checking bench for the greedy box suppression block. A short table of
// hand-picked boxes comes first, then phases of clustered, grid and noise
// boxes at several overlap thresholds. Each verdict is compared with the
// table's verdict where one is known, else with an in-bench model of the
// kept list, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module greedy_box_suppression_test import gbs_pkg::*;;

	localparam logic [2:0] ADDR_THRESHOLD = 3'd0;
	localparam logic [2:0] ADDR_SPARE     = 3'd4;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_OFF_CYCLES = 400;

	typedef struct packed {
		logic                 keep;
		logic [SLOT_BITS-1:0] slot;
		logic                 full;
	} verdict_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] left;
		logic signed [COORD_BITS-1:0] top;
		logic [SIZE_BITS-1:0]         width;
		logic [SIZE_BITS-1:0]         height;
		logic                         first;
		logic                         known;
		logic                         keep;
		logic [SLOT_BITS-1:0]         slot;
		logic                         full;
	} row_t;

	// rows with known set carry a verdict that is plain from the geometry
	localparam row_t DIRECTED [13] = '{
		'{0, 0, 160, 160, 1, 1, 1, 0, 0},
		'{0, 0, 160, 160, 0, 1, 0, 0, 0},
		'{0, 0, 0, 0, 0, 1, 1, 1, 0},
		'{0, 0, 0, 0, 0, 1, 1, 2, 0},
		'{-32768, -32768, 32767, 32767, 0, 1, 1, 3, 0},
		'{32767, 32767, 32767, 32767, 0, 1, 1, 4, 0},
		'{80, 0, 160, 160, 0, 0, 0, 0, 0},
		'{16, 0, 160, 160, 0, 0, 0, 0, 0},
		'{0, 16, 160, 144, 0, 0, 0, 0, 0},
		'{-32768, 32767, 0, 32767, 0, 0, 0, 0, 0},
		'{0, 0, 160, 160, 1, 1, 1, 0, 0},
		'{0, 0, 32767, 32767, 0, 0, 0, 0, 0},
		'{8, 8, 144, 144, 0, 0, 0, 0, 0}
	};

	logic                         clk;
	logic                         arst_n = 1'b0;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [2:0]                   paddr = '0;
	logic [31:0]                  pwdata = '0;
	logic [31:0]                  prdata;
	logic                         pready;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic signed [COORD_BITS-1:0] box_left = '0;
	logic signed [COORD_BITS-1:0] box_top = '0;
	logic [SIZE_BITS-1:0]         box_width = '0;
	logic [SIZE_BITS-1:0]         box_height = '0;
	logic                         first_of_set = 1'b0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic                         keep;
	logic [SLOT_BITS-1:0]         kept_slot;
	logic                         list_full;

	greedy_box_suppression DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.box_left(box_left), .box_top(box_top),
		.box_width(box_width), .box_height(box_height),
		.first_of_set(first_of_set),
		.out_valid(out_valid), .out_ready(out_ready),
		.keep(keep), .kept_slot(kept_slot), .list_full(list_full)
	);

	// kept-list model
	longint kept_l [MAX_KEPT];
	longint kept_t [MAX_KEPT];
	longint kept_w [MAX_KEPT];
	longint kept_h [MAX_KEPT];
	longint kept_a [MAX_KEPT];
	int     kept_total = 0;
	int     iou_limit = THR_RESET;

	verdict_t verdict_q [$];
	verdict_t head;
	int       errors = 0;
	int       idle_cycles = 0;
	bit       hold_off_req = 1'b0;
	bit       steady = 1'b0;
	int       burst_left = 0;
	int       set_left = 0;
	int       set_cx = 0;
	int       set_cy = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint lmax(longint a, longint b);
		return (a > b) ? a : b;
	endfunction

	function automatic longint lmin(longint a, longint b);
		return (a < b) ? a : b;
	endfunction

	function automatic verdict_t judge_box(box_t b, logic first);
		verdict_t v;
		longint l, t, w, h, area, ix, iy, inter, uni;
		logic survive;
		v = '0;
		survive = 1'b1;
		l = longint'(b.left);
		t = longint'(b.top);
		w = longint'(b.width);
		h = longint'(b.height);
		area = w * h;
		if (first)
			kept_total = 0;
		for (int j = 0; j < kept_total && survive; j++) begin
			ix = lmax(0, lmin(l + w, kept_l[j] + kept_w[j]) - lmax(l, kept_l[j]));
			iy = lmax(0, lmin(t + h, kept_t[j] + kept_h[j]) - lmax(t, kept_t[j]));
			inter = ix * iy;
			uni = area + kept_a[j] - inter;
			// a zero union never suppresses
			if (uni > 0 && inter * 256 > longint'(iou_limit) * uni)
				survive = 1'b0;
		end
		v.keep = survive;
		if (survive) begin
			if (kept_total < MAX_KEPT) begin
				kept_l[kept_total] = l;
				kept_t[kept_total] = t;
				kept_w[kept_total] = w;
				kept_h[kept_total] = h;
				kept_a[kept_total] = area;
				v.slot = kept_total[SLOT_BITS-1:0];
				kept_total++;
			end else begin
				v.full = 1'b1;
			end
		end
		return v;
	endfunction

	task automatic report_mismatch(string what);
		errors++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				report_mismatch("result with no request pending");
			end else begin
				head = verdict_q.pop_front();
				if (keep !== head.keep)
					report_mismatch($sformatf("keep %b, want %b", keep, head.keep));
				if (kept_slot !== head.slot)
					report_mismatch($sformatf("kept_slot %0d, want %0d", kept_slot, head.slot));
				if (list_full !== head.full)
					report_mismatch($sformatf("list_full %b, want %b", list_full, head.full));
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// receiver: switches among random stall patterns; long hold-off on demand
	initial begin
		int rx_tick;
		int rx_mode;
		rx_tick = 0;
		rx_mode = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				rx_tick++;
				if (rx_tick % 150 == 0)
					rx_mode = $urandom_range(0, 3);
				case (rx_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 5) == 0);
					default: out_ready <= ((rx_tick % 16) < 11);
				endcase
			end
		end
	end

	task automatic threshold_readback();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_THRESHOLD;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== 32'(iou_limit))
			report_mismatch($sformatf("threshold read %0d, want %0d", prdata, iou_limit));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// addresses with bit 2 set, such as the spare, are ignored
		if (addr == ADDR_THRESHOLD)
			iou_limit = data & 32'h1FF;
		threshold_readback();
	endtask

	task automatic send_box(box_t b, logic first, logic known, verdict_t want);
		verdict_t got;
		in_valid <= 1'b1;
		box_left <= b.left;
		box_top <= b.top;
		box_width <= b.width;
		box_height <= b.height;
		first_of_set <= first;
		do @(posedge clk); while (!in_ready);
		got = judge_box(b, first);
		verdict_q.insert(verdict_q.size(), known ? want : got);
	endtask

	// sender bursts with random gaps, short or long, the longest enough to span a scan
	task automatic pace();
		int gap;
		if (steady)
			return;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 9);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
	endtask

	// disjoint boxes: every one survives, so the list overflows past MAX_KEPT
	task automatic grid_set(int count);
		box_t b;
		for (int k = 0; k < count; k++) begin
			b.left = COORD_BITS'((k % 8) * 3000 - 12000);
			b.top = COORD_BITS'((k / 8) * 3000 - 15000);
			b.width = SIZE_BITS'($urandom_range(16, 2000));
			b.height = SIZE_BITS'($urandom_range(16, 2000));
			send_box(b, k == 0, 1'b0, '0);
			pace();
		end
	endtask

	// mostly clustered sets with random content, some raw noise
	task automatic random_boxes(int count);
		box_t b;
		logic first;
		logic [31:0] raw_a, raw_b;
		int ox, oy;
		for (int n = 0; n < count; n++) begin
			first = 1'b0;
			if (set_left == 0) begin
				set_left = $urandom_range(1, 24);
				set_cx = int'($urandom_range(0, 58000)) - 30000;
				set_cy = int'($urandom_range(0, 58000)) - 30000;
				first = 1'b1;
			end
			set_left--;
			if ($urandom_range(0, 7) == 0) begin
				raw_a = $urandom;
				raw_b = $urandom;
				b.left = raw_a[15:0];
				b.width = raw_a[30:16];
				b.top = raw_b[15:0];
				b.height = raw_b[30:16];
				first = raw_a[31];
			end else begin
				ox = $urandom_range(0, 1200);
				oy = $urandom_range(0, 1200);
				b.left = COORD_BITS'(set_cx + ox - 600);
				b.top = COORD_BITS'(set_cy + oy - 600);
				b.width = ($urandom_range(0, 15) == 0) ? '0 : SIZE_BITS'($urandom_range(16, 800));
				b.height = ($urandom_range(0, 15) == 0) ? '0 : SIZE_BITS'($urandom_range(16, 800));
			end
			send_box(b, first, 1'b0, '0);
			pace();
		end
	endtask

	initial begin
		int unsigned phase_thr [8];
		int unsigned thr;
		box_t b;
		verdict_t want;
		phase_thr = '{0, 256, 511, 1, 200, 0, 128, 115};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		threshold_readback();

		foreach (DIRECTED[i]) begin
			b.left = DIRECTED[i].left;
			b.top = DIRECTED[i].top;
			b.width = DIRECTED[i].width;
			b.height = DIRECTED[i].height;
			want.keep = DIRECTED[i].keep;
			want.slot = DIRECTED[i].slot;
			want.full = DIRECTED[i].full;
			send_box(b, DIRECTED[i].first, DIRECTED[i].known, want);
			pace();
		end

		for (int p = 0; p < 8; p++) begin
			wait_drained();
			repeat (4) @(posedge clk);
			thr = (p == 5) ? $urandom_range(0, 511) : phase_thr[p];
			if (p == 2)
				cfg_write(ADDR_SPARE, $urandom);
			// junk in the upper bits must be dropped
			cfg_write(ADDR_THRESHOLD, (p == 5) ? (($urandom & ~32'h1FF) | thr) : thr);
			steady = (p == 3);
			if (p == 1)
				hold_off_req = 1'b1;
			if (p == 2 || p == 7)
				grid_set((p == 2) ? 66 : 68);
			random_boxes(33);
		end

		wait_drained();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
